### design/sbdma_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sbdma_pkg: shared types and constants of the strided block DMA sequencer
// Field widths, memory geometry, operation and result codes, and the beat
// structures passed between the top level and the sequencer.
// ----------------------------------------------------------------------------
package sbdma_pkg;

  // The bank size must be a power of two.
  localparam int unsigned BANK_BYTES = 4096;
  localparam int unsigned DRAM_LIMIT = 8388608;

  localparam int unsigned DRAM_IN_W = 32;
  localparam int unsigned DRAM_W    = 24;
  localparam int unsigned LOCAL_W   = 13;
  localparam int unsigned LW_W      = 32;
  localparam int unsigned LEN_W     = 12;
  localparam int unsigned CNT_W     = 8;
  localparam int unsigned ROWS_W    = 9;
  localparam int unsigned CHK_W     = 18;
  localparam int unsigned LIM_W     = 25;

  typedef enum logic [1:0] {
    OP_TICK      = 2'd0,
    OP_START_IN  = 2'd1,
    OP_START_OUT = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    KIND_IDLE      = 3'd0,
    KIND_ACCEPTED  = 3'd1,
    KIND_RANGE_ERR = 3'd2,
    KIND_BANK_ERR  = 3'd3,
    KIND_MOVE      = 3'd4,
    KIND_BUSY      = 3'd5
  } kind_t;

  typedef struct packed {
    op_t                  op;
    logic [DRAM_IN_W-1:0] dram_address;
    logic [LOCAL_W-1:0]   local_address;
    logic [LW_W-1:0]      length_word;
  } item_t;

  typedef struct packed {
    kind_t              kind;
    logic [DRAM_W-1:0]  move_dram_address;
    logic [LOCAL_W-1:0] move_local_address;
    logic               toward_dram;
    logic               final_byte;
    logic               busy_res;
  } result_t;

endpackage
`default_nettype wire

### design/strided_block_dma_address_gen.sv
`default_nettype none
// ----------------------------------------------------------------------------
// strided_block_dma_address_gen: address sequencer of a strided block DMA
// Each input beat (start or tick) gives exactly one result beat. Beats pass
// an input register and a result register with the sequencer logic between
// them, so one beat is taken every clock when the output is not stalled. The
// per-tick work is the byte counter increment and the base-plus-index adds,
// with the base and row-count updates at the end of a row, in the sequencer.
// ----------------------------------------------------------------------------
module strided_block_dma_address_gen (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_op,
  input  wire logic [31:0] in_dram_address,
  input  wire logic [12:0] in_local_address,
  input  wire logic [31:0] in_length_word,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       out_kind,
  output logic [23:0]      out_move_dram_address,
  output logic [12:0]      out_move_local_address,
  output logic             out_toward_dram,
  output logic             out_final_byte,
  output logic             out_busy_res
);

  logic               in_vld_r, in_vld_nxt;
  sbdma_pkg::item_t   item_r;
  logic               out_vld_r, out_vld_nxt;
  sbdma_pkg::result_t res_r;
  sbdma_pkg::result_t res;
  logic               in_take;
  logic               advance;

  assign advance  = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !advance;
  assign in_take  = in_valid && !in_stall;

  assign in_vld_nxt  = in_take || (in_vld_r && !advance);
  assign out_vld_nxt = advance || (out_vld_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r.op            <= sbdma_pkg::op_t'(in_op);
      item_r.dram_address  <= in_dram_address;
      item_r.local_address <= in_local_address;
      item_r.length_word   <= in_length_word;
    end
    if (advance) begin
      res_r <= res;
    end
  end

  sbdma_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (advance),
    .item  (item_r),
    .res   (res)
  );

  assign out_valid              = out_vld_r;
  assign out_kind               = res_r.kind;
  assign out_move_dram_address  = res_r.move_dram_address;
  assign out_move_local_address = res_r.move_local_address;
  assign out_toward_dram        = res_r.toward_dram;
  assign out_final_byte         = res_r.final_byte;
  assign out_busy_res           = res_r.busy_res;

endmodule
`default_nettype wire

### design/sbdma_seq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sbdma_seq: transfer state and per-beat result logic
// Holds the transfer geometry, checks start beats and steps the row and byte
// counters by one byte move for each tick beat while a transfer is active.
// ----------------------------------------------------------------------------
module sbdma_seq (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              step,
  input  wire sbdma_pkg::item_t  item,
  output sbdma_pkg::result_t     res
);

  localparam int unsigned DW  = sbdma_pkg::DRAM_W;
  localparam int unsigned LW  = sbdma_pkg::LOCAL_W;
  localparam int unsigned RW  = sbdma_pkg::ROWS_W;
  localparam int unsigned CW  = sbdma_pkg::CHK_W;
  localparam int unsigned LMW = sbdma_pkg::LIM_W;
  localparam int unsigned NW  = sbdma_pkg::LEN_W;

  logic          active_r, active_nxt;
  logic          direction_r, direction_nxt;
  logic [DW-1:0] dram_base_r, dram_base_nxt;
  logic [LW-1:0] local_base_r, local_base_nxt;
  logic [LW-1:0] row_bytes_r, row_bytes_nxt;
  logic [LW-1:0] row_stride_r, row_stride_nxt;
  logic [RW-1:0] rows_left_r, rows_left_nxt;
  logic [LW-1:0] byte_index_r, byte_index_nxt;

  logic [NW-1:0] len_field;
  logic [DW-1:0] dram_in;
  logic          range_bad;
  logic [CW-1:0] bank_offset;
  logic          bank_bad;
  logic [LW-1:0] new_row_bytes;
  logic [DW-1:0] move_dram;
  logic [LW-1:0] move_local;
  logic [LW-1:0] index_inc;
  logic          row_end;
  logic          last_row;

  assign len_field     = item.length_word[NW-1:0];
  assign dram_in       = item.dram_address[DW-1:0];
  assign range_bad     = LMW'(dram_in) > LMW'(sbdma_pkg::DRAM_LIMIT);
  assign bank_offset   = CW'(item.local_address) & CW'(sbdma_pkg::BANK_BYTES - 1);
  assign bank_bad      = (CW'(len_field) + CW'(1) + bank_offset) >
                         CW'(sbdma_pkg::BANK_BYTES);
  assign new_row_bytes = LW'(len_field | NW'(7)) + LW'(1);

  assign move_dram  = dram_base_r + DW'(byte_index_r);
  assign move_local = local_base_r + byte_index_r;
  assign index_inc  = byte_index_r + LW'(1);
  assign row_end    = index_inc >= row_bytes_r;
  assign last_row   = rows_left_r <= RW'(1);

  always_comb begin
    active_nxt     = active_r;
    direction_nxt  = direction_r;
    dram_base_nxt  = dram_base_r;
    local_base_nxt = local_base_r;
    row_bytes_nxt  = row_bytes_r;
    row_stride_nxt = row_stride_r;
    rows_left_nxt  = rows_left_r;
    byte_index_nxt = byte_index_r;
    res            = '0;
    res.kind       = sbdma_pkg::KIND_IDLE;
    unique case (item.op)
      sbdma_pkg::OP_START_IN, sbdma_pkg::OP_START_OUT: begin
        if (active_r) begin
          res.kind     = sbdma_pkg::KIND_BUSY;
          res.busy_res = 1'b1;
        end else if (range_bad) begin
          res.kind = sbdma_pkg::KIND_RANGE_ERR;
        end else if (bank_bad) begin
          res.kind = sbdma_pkg::KIND_BANK_ERR;
        end else begin
          row_bytes_nxt  = new_row_bytes;
          row_stride_nxt = LW'(item.length_word[31:20]) + new_row_bytes;
          rows_left_nxt  = RW'(item.length_word[19:12]) + RW'(1);
          dram_base_nxt  = {dram_in[DW-1:3], 3'b000};
          local_base_nxt = {item.local_address[LW-1:3], 3'b000};
          byte_index_nxt = '0;
          direction_nxt  = (item.op == sbdma_pkg::OP_START_OUT);
          active_nxt     = 1'b1;
          res.kind        = sbdma_pkg::KIND_ACCEPTED;
          res.toward_dram = direction_nxt;
          res.busy_res    = 1'b1;
        end
      end
      sbdma_pkg::OP_TICK: begin
        if (active_r) begin
          byte_index_nxt = index_inc;
          if (row_end) begin
            byte_index_nxt = '0;
            dram_base_nxt  = dram_base_r + DW'(row_stride_r);
            local_base_nxt = local_base_r + row_bytes_r;
            if (last_row) begin
              rows_left_nxt = '0;
              active_nxt    = 1'b0;
            end else begin
              rows_left_nxt = rows_left_r - RW'(1);
            end
          end
          res.kind               = sbdma_pkg::KIND_MOVE;
          res.move_dram_address  = move_dram;
          res.move_local_address = move_local;
          res.toward_dram        = direction_r;
          res.final_byte         = row_end && last_row;
          res.busy_res           = active_nxt;
        end
      end
      default: begin
        res.busy_res = active_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r     <= 1'b0;
      direction_r  <= 1'b0;
      dram_base_r  <= '0;
      local_base_r <= '0;
      row_bytes_r  <= '0;
      row_stride_r <= '0;
      rows_left_r  <= '0;
      byte_index_r <= '0;
    end else if (step) begin
      active_r     <= active_nxt;
      direction_r  <= direction_nxt;
      dram_base_r  <= dram_base_nxt;
      local_base_r <= local_base_nxt;
      row_bytes_r  <= row_bytes_nxt;
      row_stride_r <= row_stride_nxt;
      rows_left_r  <= rows_left_nxt;
      byte_index_r <= byte_index_nxt;
    end
  end

  a_index_in_row: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> byte_index_r < row_bytes_r)
    else $error("byte index has run past the end of the row");

  a_idle_no_rows: assert property (@(posedge clk) disable iff (!rst_n)
    !active_r |-> rows_left_r == '0)
    else $error("rows remain while the sequencer is idle");

  a_final_ends: assert property (@(posedge clk) disable iff (!rst_n)
    step && res.final_byte |=> !active_r)
    else $error("transfer still active after its final byte");

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    step && res.kind == sbdma_pkg::KIND_ACCEPTED |=> active_r && rows_left_r != '0)
    else $error("accepted start did not make the sequencer busy");

endmodule
`default_nettype wire
